// ----- src/assert_macros.svh -----
// assertion helpers used by the checker file rmsn_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, sampled on clk, quiet during rst
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/rmsn_pkg.sv -----
package rmsn_pkg;
  localparam int DEFAULT_MAX_WIDTH = 64;
  localparam int VAL_W = 16;
  localparam int ACC_W = 37;
  localparam int EPS_W = 32;
  localparam int M_W = 34;
  localparam int INV_W = 37;
  localparam int ROOT_W = 112;
  localparam int ROOT_SHIFT = 72;
  localparam logic [EPS_W-1:0] EPS_RESET = 32'd17;
endpackage

// ----- src/rmsn_invroot.sv -----
module rmsn_invroot
  import rmsn_pkg::*;
#(
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [ACC_W-1:0] acc,
  input  logic [CNT_W-1:0] cnt,
  input  logic [EPS_W-1:0] eps,
  output logic             done,
  output logic [INV_W-1:0] inv
);
  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_DIV  = 2'd1;
  localparam logic [1:0] P_ADD  = 2'd2;
  localparam logic [1:0] P_ROOT = 2'd3;

  logic [1:0]        phase;
  logic [5:0]        iter;
  logic [ACC_W-1:0]  quo;
  logic [CNT_W:0]    rem;
  logic [CNT_W-1:0]  divisor;
  logic [CNT_W:0]    rem_try;
  logic [ROOT_W-1:0] p_sum;
  logic [ROOT_W-1:0] q_sh;
  logic [ROOT_W-1:0] m_sh;
  logic [ROOT_W-1:0] trial;
  logic              fits;
  logic [M_W-1:0]    m_val;

  // restoring divide step
  assign rem_try = {rem[CNT_W-1:0], quo[ACC_W-1]};
  // root step: (r + 2^b)^2 m = r^2 m + r m 2^(b+1) + m 2^(2b)
  assign trial = p_sum + q_sh + m_sh;
  assign fits = trial <= (ROOT_W'(1) << ROOT_SHIFT);
  assign m_val = M_W'(quo) + M_W'(eps);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      phase <= P_IDLE;
    end else begin
      unique case (phase)
        P_IDLE: begin
          if (go) begin
            quo <= acc;
            rem <= '0;
            divisor <= cnt;
            iter <= 6'd0;
            phase <= P_DIV;
          end
        end
        P_DIV: begin
          if (rem_try >= {1'b0, divisor}) begin
            rem <= rem_try - {1'b0, divisor};
            quo <= {quo[ACC_W-2:0], 1'b1};
          end else begin
            rem <= rem_try;
            quo <= {quo[ACC_W-2:0], 1'b0};
          end
          iter <= iter + 6'd1;
          if (iter == 6'(ACC_W - 1)) phase <= P_ADD;
        end
        P_ADD: begin
          p_sum <= '0;
          q_sh <= '0;
          m_sh <= (m_val == '0) ? (ROOT_W'(1) << (2 * (INV_W - 1)))
                                : (ROOT_W'(m_val) << (2 * (INV_W - 1)));
          iter <= 6'd0;
          phase <= P_ROOT;
        end
        P_ROOT: begin
          if (fits) begin
            p_sum <= trial;
            q_sh <= (q_sh + (m_sh << 1)) >> 1;
          end else begin
            q_sh <= q_sh >> 1;
          end
          m_sh <= m_sh >> 2;
          inv <= {inv[INV_W-2:0], fits};
          iter <= iter + 6'd1;
          if (iter == 6'(INV_W - 1)) begin
            phase <= P_IDLE;
            done <= 1'b1;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end
endmodule

// ----- src/rmsn_scale.sv -----
module rmsn_scale
  import rmsn_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_last,
  input  logic signed [VAL_W-1:0] value,
  input  logic signed [VAL_W-1:0] weight,
  input  logic [INV_W-1:0]        inv,
  output logic                    active,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_value,
  output logic                    out_last,
  output logic                    out_sat
);
  localparam int INV_LO = 20;

  logic [VAL_W-1:0]   ax, aw;
  logic               v1, l1, n1;
  logic [31:0]        prod;
  logic               v2, l2, n2;
  logic [51:0]        part_lo;
  logic [48:0]        part_hi;
  logic [69:0]        total;
  logic [33:0]        q;

  assign ax = value[VAL_W-1] ? VAL_W'(-value) : VAL_W'(value);
  assign aw = weight[VAL_W-1] ? VAL_W'(-weight) : VAL_W'(weight);
  assign total = 70'(part_lo) + (70'(part_hi) << INV_LO) + (70'(1) << 35);
  assign q = total[69:36];
  assign active = v1 | v2 | out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
    l1 <= in_last;
    n1 <= value[VAL_W-1] ^ weight[VAL_W-1];
    prod <= 32'(ax) * 32'(aw);
    l2 <= l1;
    n2 <= n1;
    part_lo <= 52'(prod) * 52'(inv[INV_LO-1:0]);
    part_hi <= 49'(prod) * 49'(inv[INV_W-1:INV_LO]);
    out_last <= l2;
    if (n2) begin
      out_sat <= q > 34'd32768;
      out_value <= (q > 34'd32768) ? -16'sd32768 : VAL_W'(-q);
    end else begin
      out_sat <= q > 34'd32767;
      out_value <= (q > 34'd32767) ? 16'sd32767 : VAL_W'(q);
    end
  end
endmodule

// ----- src/rms_row_normalizer_top.sv -----
// rms row normalizer
// input: pulse start with sample_value, column_weight and last_in_row;
// the word is taken at a clock edge where start is high and busy is low
// elements that do not end a row are taken one per cycle, busy stays low
// a row ends on last_in_row or when MAX_WIDTH elements are stored
// after the row ends busy rises; the shared divide/root unit first forms
// the mean square (one quotient bit per cycle) and then
// the inverse root (one root bit per cycle);
// then the n stored elements stream out, one result per cycle, through
// a 4-stage scale pipe (memory read, magnitude product, split product
// with the inverse, round and clamp); busy falls after the last result
// results: result_strobe marks each word for one cycle; the receiver
// cannot stall, so every strobed word must be taken at that edge
// cfg: cfg_valid/cfg_ready write epsilon (cfg_ready is always high);
// write it only while idle
// reset (rst, synchronous) empties the row, sets epsilon to 17
module rms_row_normalizer_top
  import rmsn_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [VAL_W-1:0] sample_value,
  input  logic signed [VAL_W-1:0] column_weight,
  input  logic                    last_in_row,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [EPS_W-1:0]        cfg_data,
  output logic                    result_strobe,
  output logic signed [VAL_W-1:0] normalized_value,
  output logic                    last_of_row,
  output logic                    saturated
);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);

  // sequencer states
  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_GO    = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  logic [2:0]         state;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   acc_next;
  logic [EPS_W-1:0]   epsilon;
  logic [CW-1:0]      k;
  logic               take;
  logic               row_end;
  logic [VAL_W-1:0]   mag;
  logic               inv_done;
  logic [INV_W-1:0]   inv;
  logic               rd_valid;
  logic               rd_last;
  logic [2*VAL_W-1:0] rd_data;
  logic               pipe_active;

  // value and weight of each column share one word
  logic [2*VAL_W-1:0] store [MAX_WIDTH];

  assign busy = state != S_LOAD;
  assign cfg_ready = 1'b1;
  assign take = start && !busy;
  assign mag = sample_value[VAL_W-1] ? VAL_W'(-sample_value) : VAL_W'(sample_value);
  assign acc_next = acc + ACC_W'(32'(mag) * 32'(mag));
  assign count_next = count + CW'(1);
  assign row_end = last_in_row || (count_next == CW'(MAX_WIDTH));

  always_ff @(posedge clk) begin
    if (take) store[count[AW-1:0]] <= {sample_value, column_weight};
    if (state == S_EMIT) rd_data <= store[k[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    rd_last <= (k + CW'(1)) == count;
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      acc <= '0;
      epsilon <= EPS_RESET;
      rd_valid <= 1'b0;
      k <= '0;
    end else begin
      if (cfg_valid && cfg_ready) epsilon <= cfg_data;
      rd_valid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (take) begin
            acc <= acc_next;
            count <= count_next;
            if (row_end) state <= S_GO;
          end
        end
        S_GO: state <= S_WAIT;
        S_WAIT: begin
          if (inv_done) begin
            k <= '0;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          rd_valid <= 1'b1;
          k <= k + CW'(1);
          if ((k + CW'(1)) == count) state <= S_DRAIN;
        end
        S_DRAIN: begin
          // hold off new items until the last result has left
          if (!rd_valid && !pipe_active) begin
            count <= '0;
            acc <= '0;
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  rmsn_invroot #(.CNT_W(CW)) u_root (
    .clk  (clk),
    .rst  (rst),
    .go   (state == S_GO),
    .acc  (acc),
    .cnt  (count),
    .eps  (epsilon),
    .done (inv_done),
    .inv  (inv)
  );

  rmsn_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .in_last   (rd_last),
    .value     (rd_data[2*VAL_W-1:VAL_W]),
    .weight    (rd_data[VAL_W-1:0]),
    .inv       (inv),
    .active    (pipe_active),
    .out_valid (result_strobe),
    .out_value (normalized_value),
    .out_last  (last_of_row),
    .out_sat   (saturated)
  );
endmodule

// ----- src/rmsn_checker.sv -----
`include "assert_macros.svh"
module rmsn_checker
  import rmsn_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    last_in_row,
  input logic                    result_strobe,
  input logic signed [VAL_W-1:0] normalized_value,
  input logic                    last_of_row,
  input logic                    saturated
);
  // results only come while a row is being worked
  `ASSERT_SAME(a_strobe_busy, result_strobe, busy)
  // a row end locks out input
  `ASSERT_NEXT(a_end_busy, start && !busy && last_in_row, busy)
  // the final result of a row is not directly followed by another result
  `ASSERT_NEXT(a_last_gap, result_strobe && last_of_row, !result_strobe)
  // a clamped result sits at a range limit
  `ASSERT_SAME(a_sat_limit, result_strobe && saturated,
    normalized_value == 16'sh7fff || normalized_value == -16'sh8000)
endmodule

bind rms_row_normalizer_top rmsn_checker u_chk (.*);

// ----- bench/rms_row_checker.sv -----
`timescale 1ns / 1ps

// watches the element, config and result channels and checks every result word
module rms_row_checker
  import rmsn_pkg::*;
#(
  parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic signed [VAL_W-1:0] sample_value,
  input  logic signed [VAL_W-1:0] column_weight,
  input  logic                    last_in_row,
  input  logic                    cfg_valid,
  input  logic                    cfg_ready,
  input  logic [EPS_W-1:0]        cfg_data,
  input  logic                    result_strobe,
  input  logic signed [VAL_W-1:0] normalized_value,
  input  logic                    last_of_row,
  input  logic                    saturated,
  output int                      fail_count,
  output int                      pending_words,
  output int                      rows_seen,
  output int                      sat_seen
);

  typedef struct packed {
    logic signed [VAL_W-1:0] norm;
    logic                    last;
    logic                    sat;
  } norm_word_t;

  norm_word_t              norm_due[$];
  logic signed [VAL_W-1:0] row_values[MAX_WIDTH];
  logic signed [VAL_W-1:0] row_weights[MAX_WIDTH];
  int                      row_len;
  logic [ACC_W-1:0]        sum_sq;
  logic [EPS_W-1:0]        eps_reg;

  // largest r with r*r*m <= 2^72
  function automatic logic [INV_W-1:0] inv_rms(input logic [M_W-1:0] m);
    logic [INV_W-1:0] r;
    logic [INV_W-1:0] c;
    logic [127:0]     prod;
    r = '0;
    if (m == 0) m = 1;
    for (int b = INV_W - 1; b >= 0; b--) begin
      c = r | (INV_W'(1) << b);
      prod = 128'(c) * 128'(c) * 128'(m);
      if (prod <= (128'(1) << ROOT_SHIFT)) r = c;
    end
    return r;
  endfunction

  // queue the normalized words of the finished row
  task automatic finish_row();
    logic [M_W-1:0]   m;
    logic [INV_W-1:0] inv;
    logic [16:0]      ax, aw;
    logic [127:0]     p;
    logic [127:0]     q;
    logic             neg;
    norm_word_t       w;
    m = M_W'(sum_sq / row_len) + M_W'(eps_reg);
    inv = inv_rms(m);
    for (int k = 0; k < row_len; k++) begin
      ax = row_values[k] < 0 ? 17'(-int'(row_values[k])) : 17'(row_values[k]);
      aw = row_weights[k] < 0 ? 17'(-int'(row_weights[k])) : 17'(row_weights[k]);
      neg = (row_values[k] < 0) != (row_weights[k] < 0);
      p = 128'(ax) * 128'(aw) * 128'(inv) + (128'(1) << 35);
      q = p >> 36;
      w.sat = 1'b0;
      if (neg) begin
        if (q > 32768) begin
          q = 32768;
          w.sat = 1'b1;
        end
        w.norm = VAL_W'(-q);
      end else begin
        if (q > 32767) begin
          q = 32767;
          w.sat = 1'b1;
        end
        w.norm = VAL_W'(q);
      end
      w.last = (k == row_len - 1);
      norm_due = {norm_due, w};
    end
    row_len = 0;
    sum_sq = '0;
  endtask

  assign pending_words = norm_due.size();

  always @(posedge clk) begin
    norm_word_t exp_w;
    int         mag;
    if (rst) begin
      norm_due.delete();
      row_len = 0;
      sum_sq = '0;
      eps_reg = EPS_RESET;
      fail_count <= 0;
      rows_seen <= 0;
      sat_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) eps_reg = cfg_data;
      if (start && !busy) begin
        row_values[row_len] = sample_value;
        row_weights[row_len] = column_weight;
        row_len = row_len + 1;
        mag = sample_value < 0 ? -int'(sample_value) : int'(sample_value);
        sum_sq = sum_sq + ACC_W'(longint'(mag) * mag);
        if (last_in_row || row_len == MAX_WIDTH) finish_row();
      end
      if (result_strobe) begin
        if (norm_due.size() == 0) begin
          $display("%0t: unexpected word norm=%0d last=%b sat=%b", $time,
                   normalized_value, last_of_row, saturated);
          fail_count <= fail_count + 1;
        end else begin
          exp_w = norm_due.pop_front();
          if (exp_w.last) rows_seen <= rows_seen + 1;
          if (exp_w.sat) sat_seen <= sat_seen + 1;
          if (exp_w.norm !== normalized_value || exp_w.last !== last_of_row
              || exp_w.sat !== saturated) begin
            $display("%0t: mismatch expected norm=%0d last=%b sat=%b, %s",
                     $time, exp_w.norm, exp_w.last, exp_w.sat,
                     $sformatf("got norm=%0d last=%b sat=%b",
                               normalized_value, last_of_row, saturated));
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ----- bench/tb_rms_row_normalizer_top.sv -----
`timescale 1ns / 1ps

module tb_rms_row_normalizer_top;
  import rmsn_pkg::*;

  localparam int MAXW = DEFAULT_MAX_WIDTH;
  localparam int ITEM_TARGET = 320;
  localparam int CYCLE_LIMIT = 400000;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic signed [VAL_W-1:0] sample_value;
  logic signed [VAL_W-1:0] column_weight;
  logic                    last_in_row;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [EPS_W-1:0]        cfg_data;
  logic                    result_strobe;
  logic signed [VAL_W-1:0] normalized_value;
  logic                    last_of_row;
  logic                    saturated;

  int fail_count, pending_words, rows_seen, sat_seen;
  int cycles;
  int items_sent;
  int burst_left;

  rms_row_normalizer_top #(.MAX_WIDTH(MAXW)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sample_value(sample_value), .column_weight(column_weight),
    .last_in_row(last_in_row), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .result_strobe(result_strobe),
    .normalized_value(normalized_value), .last_of_row(last_of_row),
    .saturated(saturated)
  );

  rms_row_checker #(.MAX_WIDTH(MAXW)) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .sample_value(sample_value), .column_weight(column_weight),
    .last_in_row(last_in_row), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .result_strobe(result_strobe),
    .normalized_value(normalized_value), .last_of_row(last_of_row),
    .saturated(saturated), .fail_count(fail_count),
    .pending_words(pending_words), .rows_seen(rows_seen), .sat_seen(sat_seen)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("rms_row_normalizer_top regression: fail");
      $finish;
    end
  end

  // one element word; the sender works in bursts with random gaps between
  task automatic send_elem(input logic signed [VAL_W-1:0] v,
                           input logic signed [VAL_W-1:0] w, input logic lst);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    sample_value <= v;
    column_weight <= w;
    last_in_row <= lst;
    // word is taken at the first edge where busy is low
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // bring the pipe to rest before touching epsilon
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_words != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_eps(input logic [EPS_W-1:0] eps);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= eps;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // random element, biased toward extremes and small magnitudes
  function automatic logic signed [VAL_W-1:0] pick_val();
    case ($urandom_range(5, 0))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return VAL_W'($urandom_range(64, 0)) - 16'sd32;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  task automatic random_row(input int len, input logic force_last);
    for (int k = 0; k < len; k++)
      send_elem(pick_val(), pick_val(), force_last && (k == len - 1));
  endtask

  initial begin
    int len;
    items_sent = 0;
    burst_left = 0;
    rst = 1'b1;
    start = 1'b0;
    sample_value = '0;
    column_weight = '0;
    last_in_row = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes with reset epsilon
    send_elem(16'sh8000, 16'sh8000, 1'b0);
    send_elem(16'sh7fff, 16'sh7fff, 1'b0);
    send_elem(16'sh0000, 16'sh8000, 1'b0);
    send_elem(-16'sd1, 16'sh7fff, 1'b0);
    send_elem(16'sd1, -16'sd1, 1'b1);
    // single-element rows: large weights in both signs
    send_elem(16'sh8000, 16'sh7fff, 1'b1);
    send_elem(16'sh7fff, 16'sh7fff, 1'b1);
    send_elem(16'sd1, 16'sh8000, 1'b1);
    // one large element among tiny ones saturates
    send_elem(16'sd3, 16'sh7fff, 1'b0);
    send_elem(-16'sd2, 16'sh7fff, 1'b0);
    send_elem(16'sh7000, 16'sh8000, 1'b1);

    // zero epsilon with an all-zero row
    write_eps(32'd0);
    send_elem(16'sd0, 16'sh7fff, 1'b0);
    send_elem(16'sd0, 16'sh8000, 1'b1);
    send_elem(16'sd0, 16'sd0, 1'b1);

    write_eps(32'd1);
    send_elem(16'sd1, 16'sd4096, 1'b1);
    write_eps(32'hffff_ffff);
    send_elem(16'sh7fff, 16'sh7fff, 1'b0);
    send_elem(16'sh8000, 16'sh7fff, 1'b1);

    // full row with no last mark ends itself at the store size
    write_eps(32'd17);
    random_row(MAXW, 1'b0);

    // random part: epsilon changes between phases
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(4, 0))
        0: write_eps(32'd1);
        1: write_eps(32'hffff_ffff);
        2: write_eps(EPS_RESET);
        default: write_eps($urandom_range(32'hffff, 1) << $urandom_range(16, 0));
      endcase
      for (int r = 0; r < 12 && items_sent < ITEM_TARGET; r++) begin
        case ($urandom_range(9, 0))
          0: len = MAXW;
          1: len = $urandom_range(MAXW - 1, 16);
          default: len = $urandom_range(8, 1);
        endcase
        random_row(len, len != MAXW || $urandom_range(1, 0) == 1);
      end
    end

    drain();
    $display("rows checked: %0d, clamped words: %0d, elements sent: %0d",
             rows_seen, sat_seen, items_sent);
    if (fail_count == 0) begin
      $display("rms_row_normalizer_top regression: pass");
    end else begin
      $display("rms_row_normalizer_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- rms_row_normalizer_top.f -----
+incdir+src
src/rmsn_pkg.sv
src/rmsn_invroot.sv
src/rmsn_scale.sv
src/rms_row_normalizer_top.sv
src/rmsn_checker.sv
bench/rms_row_checker.sv
bench/tb_rms_row_normalizer_top.sv
